// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check is clocked on the rising edge and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// When the trigger holds, the consequence holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed");

// When the trigger holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gnc_pkg.sv =====
`default_nettype none

package gnc_pkg;

  // Default sizes.
  localparam int unsigned MAX_ALLELES_DEF = 16;
  localparam int unsigned MAX_PLOIDY_DEF  = 8;

  localparam int unsigned CODE_W     = 27;
  localparam int unsigned NUC_W      = 4;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;

  // Input item tags.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_REF = 2'd0,
    FUNC_ALT = 2'd1,
    FUNC_GT  = 2'd2,
    FUNC_EOL = 2'd3
  } func_e;

  // Configuration register indices.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_UNIFORM = 3'd0,
    REG_CODE_A       = 3'd1,
    REG_CODE_C       = 3'd2,
    REG_CODE_G       = 3'd3,
    REG_CODE_T       = 3'd4,
    REG_CODE_MISSING = 3'd5
  } reg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_EOL    = 1'b1
  } kind_e;

  // Reset values of the code digit registers.
  localparam logic [NUC_W-1:0] CODE_A_RST       = 4'd4;
  localparam logic [NUC_W-1:0] CODE_C_RST       = 4'd2;
  localparam logic [NUC_W-1:0] CODE_G_RST       = 4'd3;
  localparam logic [NUC_W-1:0] CODE_T_RST       = 4'd1;
  localparam logic [NUC_W-1:0] CODE_MISSING_RST = 4'd5;

  // Characters of interest.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;

  typedef struct packed {
    logic [NUC_W-1:0] a;
    logic [NUC_W-1:0] c;
    logic [NUC_W-1:0] g;
    logic [NUC_W-1:0] t;
    logic [NUC_W-1:0] missing;
  } nuc_codes_t;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
    logic              err;
    logic              keep;
  } result_t;

  // Code digit of a base letter; anything that is not a base gets the missing digit.
  function automatic logic [NUC_W-1:0] map_base(input logic [CHAR_W-1:0] c,
                                                 input nuc_codes_t codes);
    logic [NUC_W-1:0] r;
    unique case (c)
      8'h41, 8'h61: r = codes.a;
      8'h43, 8'h63: r = codes.c;
      8'h47, 8'h67: r = codes.g;
      8'h54, 8'h74: r = codes.t;
      default:      r = codes.missing;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(input logic [CHAR_W-1:0] c);
    return (c == CH_COLON) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_NUL);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/genotype_nucleotide_coder.sv =====
// A result is registered in the result register, or first in its skid stage when that is held.
// Throughput: one input transfer per cycle; the parse state and the allele store are
// updated by a single pass of logic per byte, and the store read is fetched ahead.
// The input stalls only when the result register and its skid stage are both full.
// Reset (rst_ni, asynchronous, active low) clears all control and line state and loads
// the default code digits; the allele store itself is not cleared.
`default_nettype none

`include "assert_macros.svh"

module genotype_nucleotide_coder #(
  parameter int unsigned MAX_ALLELES = gnc_pkg::MAX_ALLELES_DEF,
  parameter int unsigned MAX_PLOIDY  = gnc_pkg::MAX_PLOIDY_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gnc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [gnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input byte channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [gnc_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [gnc_pkg::CHAR_W-1:0]     char_byte_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               result_kind_o,
  output logic      [gnc_pkg::CODE_W-1:0]     sample_code_o,
  output logic                               sample_error_o,
  output logic                               line_keep_o
);
  import gnc_pkg::*;

  // Address width of the allele store, width of the index accumulator (which has to
  // hold MAX_ALLELES itself as its saturation value) and of the digit count.
  localparam int unsigned AW = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1;
  localparam int unsigned IW = $clog2(MAX_ALLELES + 1);
  localparam int unsigned VW = IW + 4;
  localparam int unsigned DW = $clog2(MAX_PLOIDY + 1);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [DW-1:0]     digits;
    logic              failed;
  } sample_t;

  // Appends one code digit to the sample, or marks it failed when the ploidy is used up.
  function automatic sample_t append(input sample_t s, input logic [NUC_W-1:0] d);
    sample_t r;
    r = s;
    if (!s.failed) begin
      if (s.digits >= DW'(MAX_PLOIDY)) begin
        r.failed = 1'b1;
      end else begin
        r.code   = (s.code << 3) + (s.code << 1) + CODE_W'(d);
        r.digits = s.digits + 1'b1;
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic       drop_q;
  nuc_codes_t codes_q;

  // Line and sample state.
  logic [AW-1:0]   last_q, last_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            in_num_q, in_num_d;
  sample_t         samp_q, samp_d;
  logic [CODE_W:0] prev_q, prev_d;
  logic            seen_q, seen_d;
  logic            keep_q, keep_d;

  // Allele store interface.
  logic             tbl_we;
  logic [AW-1:0]    tbl_waddr;
  logic [NUC_W-1:0] tbl_wdata;
  logic [NUC_W-1:0] tbl_rdata;

  logic            in_fire;
  logic            push;
  result_t         res;
  result_t         out_res;
  logic [VW-1:0]   idx_next;
  logic [CODE_W:0] cur_mark;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q          <= 1'b0;
      codes_q.a       <= CODE_A_RST;
      codes_q.c       <= CODE_C_RST;
      codes_q.g       <= CODE_G_RST;
      codes_q.t       <= CODE_T_RST;
      codes_q.missing <= CODE_MISSING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DROP_UNIFORM: drop_q          <= cfg_data_i[0];
        REG_CODE_A:       codes_q.a       <= cfg_data_i;
        REG_CODE_C:       codes_q.c       <= cfg_data_i;
        REG_CODE_G:       codes_q.g       <= cfg_data_i;
        REG_CODE_T:       codes_q.t       <= cfg_data_i;
        REG_CODE_MISSING: codes_q.missing <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The decimal value of an allele index digit is the low nibble of its character.
  assign idx_next = (VW'(idx_q) << 3) + (VW'(idx_q) << 1) + VW'(char_byte_i[3:0]);

  // Next-state logic for one byte. A genotype byte may both close an index number and
  // append the missing digit for a dot, so up to two digits go in within one pass.
  always_comb begin
    last_d    = last_q;
    idx_d     = idx_q;
    in_num_d  = in_num_q;
    samp_d    = samp_q;
    prev_d    = prev_q;
    seen_d    = seen_q;
    keep_d    = keep_q;
    tbl_we    = 1'b0;
    tbl_waddr = last_q;
    tbl_wdata = map_base(char_byte_i, codes_q);
    push      = 1'b0;
    res       = '0;
    cur_mark  = '0;

    if (in_fire) begin
      unique case (func_i)
        FUNC_REF: begin
          samp_d    = '0;
          idx_d     = '0;
          in_num_d  = 1'b0;
          last_d    = '0;
          tbl_we    = 1'b1;
          tbl_waddr = '0;
          seen_d    = 1'b0;
          keep_d    = !drop_q;
        end
        FUNC_ALT: begin
          if (char_byte_i == CH_COMMA) begin
            // The last entry absorbs any further alleles.
            if (last_q < AW'(MAX_ALLELES - 1)) begin
              last_d = last_q + 1'b1;
            end
          end else if (char_byte_i != CH_TAB) begin
            tbl_we = 1'b1;
          end
        end
        FUNC_EOL: begin
          samp_d    = '0;
          idx_d     = '0;
          in_num_d  = 1'b0;
          push      = 1'b1;
          res.kind  = KIND_EOL;
          res.keep  = keep_q;
        end
        FUNC_GT: begin
          if (is_digit(char_byte_i)) begin
            if (!samp_q.failed) begin
              idx_d = (idx_next > VW'(MAX_ALLELES)) ? IW'(MAX_ALLELES) : IW'(idx_next);
            end
            in_num_d = 1'b1;
          end else begin
            if (in_num_q) begin
              in_num_d = 1'b0;
              if (!samp_q.failed) begin
                if (idx_q > IW'(last_q)) begin
                  samp_d.failed = 1'b1;
                end else begin
                  samp_d = append(samp_q, tbl_rdata);
                end
              end
              idx_d = '0;
            end
            priority if (is_delim(char_byte_i)) begin
              // A failed sample compares as a value no code can take.
              cur_mark  = samp_d.failed ? {1'b1, {CODE_W{1'b0}}} : {1'b0, samp_d.code};
              push      = 1'b1;
              res.kind  = KIND_SAMPLE;
              res.code  = samp_d.failed ? '0 : samp_d.code;
              res.err   = samp_d.failed;
              if (!keep_q && seen_q) begin
                keep_d = (prev_q != cur_mark);
              end
              prev_d   = cur_mark;
              seen_d   = 1'b1;
              samp_d   = '0;
              idx_d    = '0;
              in_num_d = 1'b0;
            end else if (char_byte_i == CH_DOT) begin
              samp_d = append(samp_d, codes_q.missing);
            end else if ((char_byte_i != CH_SLASH) && (char_byte_i != CH_BAR)) begin
              samp_d.failed = 1'b1;
            end else begin
              // Allele dividers carry no information here.
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      idx_q    <= '0;
      in_num_q <= 1'b0;
      samp_q   <= '0;
      prev_q   <= '0;
      seen_q   <= 1'b0;
      keep_q   <= 1'b0;
    end else begin
      last_q   <= last_d;
      idx_q    <= idx_d;
      in_num_q <= in_num_d;
      samp_q   <= samp_d;
      prev_q   <= prev_d;
      seen_q   <= seen_d;
      keep_q   <= keep_d;
    end
  end

  // The store is read at the next index value, so the entry for idx_q is ready
  // when the byte that closes the number arrives.
  gnc_table #(
    .DEPTH (MAX_ALLELES)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  gnc_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (res),
    .can_accept_o (in_ready_o),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .data_o       (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign sample_code_o  = out_res.code;
  assign sample_error_o = out_res.err;
  assign line_keep_o    = out_res.keep;

  `ASSERT_ALWAYS(a_idx_saturates, clk_i, rst_ni, idx_q <= IW'(MAX_ALLELES))
  `ASSERT_ALWAYS(a_last_in_range, clk_i, rst_ni, last_q <= AW'(MAX_ALLELES - 1))
  `ASSERT_ALWAYS(a_ploidy_bound, clk_i, rst_ni, samp_q.digits <= DW'(MAX_PLOIDY))
  `ASSERT_NEXT(a_ref_starts_line, clk_i, rst_ni, in_fire && (func_i == FUNC_REF),
               !seen_q && (last_q == '0) && !samp_q.failed)

endmodule

`default_nettype wire

// ===== rtl/gnc_table.sv =====
`default_nettype none

// Allele-to-code store with a registered read. A write to the address being read
// in the same cycle is forwarded, so the read data always reflect the latest write.
module gnc_table #(
  parameter int unsigned DEPTH = gnc_pkg::MAX_ALLELES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [gnc_pkg::NUC_W-1:0] wdata_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [gnc_pkg::NUC_W-1:0] rdata_o
);
  import gnc_pkg::*;

  logic [NUC_W-1:0] store_q [DEPTH];
  logic [NUC_W-1:0] rd_mem_q;
  logic [NUC_W-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    rd_mem_q   <= store_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_mem_q;

endmodule

`default_nettype wire

// ===== rtl/gnc_out_buf.sv =====
`default_nettype none

`include "assert_macros.svh"

// Result register with a skid stage behind it.
module gnc_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire gnc_pkg::result_t push_data_i,
  output logic                  can_accept_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output gnc_pkg::result_t      data_o
);
  import gnc_pkg::*;

  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    pop;

  assign pop = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign can_accept_o = !skid_valid_q;
  assign valid_o      = out_valid_q;
  assign data_o       = out_q;

  `ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `ASSERT_IMPL(a_no_push_when_full, clk_i, rst_ni, skid_valid_q, !push_i)
  `ASSERT_NEXT(a_stall_fills_skid, clk_i, rst_ni, push_i && out_valid_q && !ready_i,
               skid_valid_q)

endmodule

`default_nettype wire

// ===== tb/gnc_checker.sv =====
`timescale 1ns / 100ps

module gnc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [gnc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [gnc_pkg::FUNC_W-1:0]     func_i,
  input  logic [gnc_pkg::CHAR_W-1:0]     char_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           result_kind_i,
  input  logic [gnc_pkg::CODE_W-1:0]     sample_code_i,
  input  logic                           sample_error_i,
  input  logic                           line_keep_i,
  output int unsigned                    failures_o,
  output int unsigned                    pending_o,
  output int unsigned                    samples_o,
  output int unsigned                    bad_samples_o,
  output int unsigned                    lines_o
);
  import gnc_pkg::*;

  localparam int unsigned ALLELES = MAX_ALLELES_DEF;
  localparam int unsigned PLOIDY  = MAX_PLOIDY_DEF;
  localparam int unsigned IDX_W   = $clog2(ALLELES);
  // A failed sample compares as a value that no real code can take.
  localparam logic [CODE_W:0] FAILED_CODE = {1'b1, {CODE_W{1'b0}}};

  logic              drop_uniform;
  nuc_codes_t        digits;
  logic [NUC_W-1:0]  allele_digit [ALLELES];
  int unsigned       last_allele;
  logic [CODE_W-1:0] code_acc;
  int unsigned       digit_count;
  int unsigned       index_acc;
  logic              in_index;
  logic              sample_bad;
  logic              sample_seen;
  logic              keep_line;
  logic [CODE_W:0]   prev_code;
  result_t           pending_results[$];
  result_t           oldest;

  function automatic logic [NUC_W-1:0] digit_for_base(input logic [CHAR_W-1:0] ch);
    case (ch)
      "A", "a": return digits.a;
      "C", "c": return digits.c;
      "G", "g": return digits.g;
      "T", "t": return digits.t;
      default:  return digits.missing;
    endcase
  endfunction

  function automatic void clear_sample();
    code_acc    = '0;
    digit_count = 0;
    index_acc   = 0;
    in_index    = 1'b0;
    sample_bad  = 1'b0;
  endfunction

  function automatic void append_digit(input logic [NUC_W-1:0] d);
    logic [31:0] wide;
    if (sample_bad) return;
    if (digit_count >= PLOIDY) begin
      sample_bad = 1'b1;
      return;
    end
    wide        = {5'd0, code_acc} * 32'd10 + {28'd0, d};
    code_acc    = wide[CODE_W-1:0];
    digit_count = digit_count + 1;
  endfunction

  function automatic void close_index();
    in_index = 1'b0;
    if (sample_bad) return;
    if (index_acc > last_allele || index_acc >= ALLELES) begin
      sample_bad = 1'b1;
      return;
    end
    append_digit(allele_digit[index_acc[IDX_W-1:0]]);
  endfunction

  function automatic void reset_model();
    drop_uniform  = 1'b0;
    digits        = '{a: CODE_A_RST, c: CODE_C_RST, g: CODE_G_RST, t: CODE_T_RST,
                      missing: CODE_MISSING_RST};
    foreach (allele_digit[i]) allele_digit[i] = '0;
    last_allele   = 0;
    clear_sample();
    prev_code     = '0;
    sample_seen   = 1'b0;
    keep_line     = 1'b0;
    pending_results.delete();
    failures_o    = 0;
    samples_o     = 0;
    bad_samples_o = 0;
    lines_o       = 0;
  endfunction

  function automatic void write_register(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DROP_UNIFORM: drop_uniform    = val[0];
      REG_CODE_A:       digits.a        = val;
      REG_CODE_C:       digits.c        = val;
      REG_CODE_G:       digits.g        = val;
      REG_CODE_T:       digits.t        = val;
      REG_CODE_MISSING: digits.missing  = val;
      default: ;
    endcase
  endfunction

  // Advances the line state by one byte and queues the result it gives, if any.
  function automatic void predict(input func_e f, input logic [CHAR_W-1:0] ch);
    result_t         res;
    logic [CODE_W:0] cur;
    case (f)
      FUNC_REF: begin
        clear_sample();
        last_allele     = 0;
        allele_digit[0] = digit_for_base(ch);
        sample_seen     = 1'b0;
        keep_line       = !drop_uniform;
      end
      FUNC_ALT: begin
        if (ch == CH_COMMA) begin
          if (last_allele < ALLELES - 1) last_allele = last_allele + 1;
        end else if (ch != CH_TAB) begin
          allele_digit[last_allele[IDX_W-1:0]] = digit_for_base(ch);
        end
      end
      FUNC_EOL: begin
        clear_sample();
        res.kind = KIND_EOL;
        res.code = '0;
        res.err  = 1'b0;
        res.keep = keep_line;
        pending_results.push_back(res);
        lines_o = lines_o + 1;
      end
      default: begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          if (!sample_bad) begin
            index_acc = index_acc * 10 + 32'(ch - CH_ZERO);
            if (index_acc > ALLELES) index_acc = ALLELES;
          end
          in_index = 1'b1;
        end else begin
          if (in_index) begin
            close_index();
            index_acc = 0;
          end
          if (ch == CH_COLON || ch == CH_TAB || ch == CH_LF || ch == CH_CR || ch == CH_NUL) begin
            cur      = sample_bad ? FAILED_CODE : {1'b0, code_acc};
            res.kind = KIND_SAMPLE;
            res.code = sample_bad ? '0 : code_acc;
            res.err  = sample_bad;
            res.keep = 1'b0;
            pending_results.push_back(res);
            samples_o = samples_o + 1;
            if (sample_bad) bad_samples_o = bad_samples_o + 1;
            if (!keep_line && sample_seen) keep_line = (prev_code != cur);
            prev_code   = cur;
            sample_seen = 1'b1;
            clear_sample();
          end else if (ch == CH_DOT) begin
            append_digit(digits.missing);
          end else if (ch != CH_SLASH && ch != CH_BAR) begin
            sample_bad = 1'b1;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures_o = failures_o + 1;
    end
  endfunction

  // A result is registered in the block before it reaches the output, so comparing
  // before predicting at the same edge is safe.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_register(reg_idx_e'(cfg_index_i), cfg_data_i);
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, actual kind %0d code %0d error %0d keep %0d",
                   $time, result_kind_i, sample_code_i, sample_error_i, line_keep_i);
          failures_o = failures_o + 1;
        end else begin
          oldest = pending_results.pop_front();
          check_field("result_kind", 32'(oldest.kind), 32'(result_kind_i));
          check_field("sample_code", 32'(oldest.code), 32'(sample_code_i));
          check_field("sample_error", 32'(oldest.err), 32'(sample_error_i));
          check_field("line_keep", 32'(oldest.keep), 32'(line_keep_i));
        end
      end
      if (in_valid_i && in_ready_i) predict(func_e'(func_i), char_byte_i);
    end
    pending_o = pending_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Top level of the genotype coder testbench. It only makes stimulus and gives
// the verdict; the checker beside the block follows every transfer, predicts
// the results and compares them.
module testbench;
  import gnc_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned ALLELES      = MAX_ALLELES_DEF;
  localparam int unsigned PLOIDY       = MAX_PLOIDY_DEF;
  // A correct run is never quiet for long: the longest
  // sender gap, the longest receiver stall and the drain before a register
  // write together stay well under this.
  localparam int unsigned QUIET_LIMIT  = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func      = '0;
  logic [CHAR_W-1:0]     char_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  result_kind;
  logic [CODE_W-1:0]     sample_code;
  logic                  sample_error;
  logic                  line_keep;
  logic                  moved;

  int unsigned failures, pending, samples, bad_samples, lines;

  // Sender and receiver pacing.
  int unsigned burst_left     = 0;
  int unsigned calm_left      = 0;
  int unsigned stall_left     = 0;
  int unsigned mode_left      = 0;
  bit          eager          = 1'b0;
  int unsigned items_sent     = 0;
  int unsigned settings_count = 0;

  // Genotype text of the sample being sent; kept so that a later sample of
  // the same line can repeat it and give an identical code.
  logic [CHAR_W-1:0] sample_text[$];

  always #(HALF_PERIOD) clk = ~clk;

  genotype_nucleotide_coder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .char_byte_i   (char_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind),
    .sample_code_o (sample_code),
    .sample_error_o(sample_error),
    .line_keep_o   (line_keep)
  );

  gnc_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .char_byte_i   (char_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_i (result_kind),
    .sample_code_i (sample_code),
    .sample_error_i(sample_error),
    .line_keep_i   (line_keep),
    .failures_o    (failures),
    .pending_o     (pending),
    .samples_o     (samples),
    .bad_samples_o (bad_samples),
    .lines_o       (lines)
  );

  // The receiver alternates between stretches where it starts no new stall and
  // stretches where it stalls often.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!eager && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 300);
      eager     = 1'($urandom_range(0, 1));
    end else begin
      mode_left = mode_left - 1;
    end
  end

  // Any transfer on any of the three channels counts as progress.
  assign moved = (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready);

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (moved) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time, quiet, pending);
    $display("== FAIL ==");
    $finish;
  end

  // Offers one byte and returns at the edge where it is transferred. The
  // sender works in bursts; between bursts valid drops for a random gap,
  // except in calm stretches where bursts follow each other directly.
  task automatic send_item(input func_e f, input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (calm_left != 0) begin
        calm_left = calm_left - 1;
        gap       = 0;
      end else begin
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 5) == 0) calm_left = $urandom_range(3, 10);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid  <= 1'b1;
    func      <= f;
    char_byte <= ch;
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
  endtask

  // Holds the input back until every expected result has been received, then
  // waits further so that a byte that causes no result can settle.
  task automatic pause_until_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic drop, input logic [NUC_W-1:0] a, c, g, t, miss);
    pause_until_drained();
    write_reg(REG_DROP_UNIFORM, {{(CFG_DATA_W-1){1'b0}}, drop});
    write_reg(REG_CODE_A, a);
    write_reg(REG_CODE_C, c);
    write_reg(REG_CODE_G, g);
    write_reg(REG_CODE_T, t);
    write_reg(REG_CODE_MISSING, miss);
    cfg_valid <= 1'b0;
    settings_count = settings_count + 1;
  endtask

  // Mostly a base letter in either case; where allowed, now and then an unknown
  // base or any byte at all.
  function automatic logic [CHAR_W-1:0] pick_base(input bit any_byte);
    case ($urandom_range(0, any_byte ? 9 : 7))
      0:       return "A";
      1:       return "C";
      2:       return "G";
      3:       return "T";
      4:       return "a";
      5:       return "c";
      6:       return "g";
      7:       return "t";
      8:       return "N";
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_delimiter();
    case ($urandom_range(0, 4))
      0:       return CH_COLON;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic void push_number(input int unsigned v);
    if (v >= 100) sample_text.push_back(CH_ZERO + CHAR_W'(v / 100));
    if (v >= 10) sample_text.push_back(CH_ZERO + CHAR_W'((v / 10) % 10));
    sample_text.push_back(CH_ZERO + CHAR_W'(v % 10));
  endfunction

  // Builds the text of one sample: mostly valid indices of the current line,
  // with dots, indices past the last allele, stray bytes, leading zeros and
  // now and then more alleles than the block takes.
  function automatic void build_sample(input int unsigned last_allele);
    int unsigned alleles, r;
    sample_text.delete();
    alleles = ($urandom_range(0, 11) == 0) ? $urandom_range(PLOIDY, PLOIDY + 2)
                                           : $urandom_range(1, 3);
    for (int unsigned a = 0; a < alleles; a++) begin
      if (a != 0) sample_text.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BAR);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        sample_text.push_back(CH_DOT);
      end else if (r == 1) begin
        push_number($urandom_range(last_allele + 1, 120));
      end else if (r == 2) begin
        sample_text.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        if (r == 3) sample_text.push_back(CH_ZERO);
        push_number($urandom_range(0, last_allele));
      end
    end
    sample_text.push_back(pick_delimiter());
  endfunction

  // One well-formed variant line with random content. With full set, the line
  // has the largest allele count and every allele is non-empty, so that every
  // table entry has been written before any random genotype is sent.
  task automatic send_line(input bit full);
    int unsigned commas, n_bytes, n_samples, last_allele;
    send_item(FUNC_REF, pick_base(!full));
    if (!full && $urandom_range(0, 5) == 0) send_item(FUNC_ALT, pick_base(1'b1));
    if (full) commas = ALLELES - 1;
    else if ($urandom_range(0, 9) == 0) commas = $urandom_range(4, ALLELES + 2);
    else commas = $urandom_range(0, 3);
    for (int unsigned k = 0; k < commas; k++) begin
      send_item(FUNC_ALT, CH_COMMA);
      // An empty allele leaves the entry from an earlier line in place.
      n_bytes = full ? $urandom_range(1, 3) : $urandom_range(0, 3);
      repeat (n_bytes) begin
        if (!full && $urandom_range(0, 7) == 0) send_item(FUNC_ALT, CH_TAB);
        else send_item(FUNC_ALT, pick_base(!full));
      end
    end
    last_allele = (commas > ALLELES - 1) ? ALLELES - 1 : commas;
    n_samples = $urandom_range(1, 5);
    for (int unsigned s = 0; s < n_samples; s++) begin
      // Repeating the previous text makes uniform lines common.
      if (s == 0 || $urandom_range(0, 2) != 0) build_sample(last_allele);
      for (int unsigned k = 0; k < sample_text.size(); k++) send_item(FUNC_GT, sample_text[k]);
    end
    // Sometimes the line ends in the middle of a sample.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(FUNC_GT, CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    end
    send_item(FUNC_EOL, CHAR_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) send_item(FUNC_EOL, CHAR_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int unsigned random_start, phase_start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the default code digits (A 4, C 2, G 3, T 1, missing 5).
    send_item(FUNC_EOL, CH_NUL);      // end of line before any line: not kept
    send_item(FUNC_REF, "T");         // allele 0 is T
    send_item(FUNC_ALT, CH_COMMA);
    send_item(FUNC_ALT, "G");
    send_item(FUNC_ALT, "c");         // the last byte of a longer allele wins
    send_item(FUNC_ALT, CH_TAB);      // ignored
    send_item(FUNC_ALT, CH_COMMA);
    send_item(FUNC_ALT, "N");         // not a base: takes the missing digit
    send_item(FUNC_GT, "0");          // both dividers, three alleles: code 125
    send_item(FUNC_GT, CH_BAR);
    send_item(FUNC_GT, "1");
    send_item(FUNC_GT, CH_SLASH);
    send_item(FUNC_GT, "2");
    send_item(FUNC_GT, CH_COLON);
    send_item(FUNC_GT, CH_DOT);       // a missing allele
    send_item(FUNC_GT, CH_LF);
    send_item(FUNC_GT, "3");          // past the last allele of the line
    send_item(FUNC_GT, CH_CR);
    send_item(FUNC_GT, 8'hFF);        // not a genotype character
    send_item(FUNC_GT, CH_NUL);
    send_item(FUNC_GT, "1");          // partial sample, dropped at end of line
    send_item(FUNC_EOL, 8'h00);
    send_item(FUNC_EOL, 8'hFF);       // a repeated end of line repeats the answer

    // Random part in phases, each with its own register setting. The first two
    // settings are the extremes; the table is filled completely before any
    // random genotype is sent.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case (settings_count)
        0: load_settings(1'b1, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9);
        1: load_settings(1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        default: load_settings(1'($urandom_range(0, 1)), NUC_W'($urandom_range(0, 9)),
                               NUC_W'($urandom_range(0, 9)), NUC_W'($urandom_range(0, 9)),
                               NUC_W'($urandom_range(0, 9)), NUC_W'($urandom_range(0, 9)));
      endcase
      if (settings_count == 1) send_line(1'b1);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - random_start < RANDOM_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 8)) begin
            send_item(func_e'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
          end
        end else begin
          send_line(1'b0);
        end
      end
    end

    pause_until_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes under %0d register settings.", items_sent, settings_count + 1);
    $display("Checked %0d sample results (%0d with an error) and %0d end of line results.",
             samples, bad_samples, lines);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gnc_pkg.sv
rtl/gnc_table.sv
rtl/gnc_out_buf.sv
rtl/genotype_nucleotide_coder.sv
tb/gnc_checker.sv
tb/testbench.sv
